// ===== rtl/bavg_pkg.sv =====
package bavg_pkg;

    // Field and register widths
    localparam int PIXEL_W      = 8;
    localparam int IMG_W_REG_W  = 11;
    localparam int IMG_H_REG_W  = 13;
    localparam int FACTOR_REG_W = 5;
    localparam int CFG_DATA_W   = 13;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int QUEUE_DEPTH  = 4;

    // Register reset values
    localparam logic [IMG_W_REG_W-1:0]  IMG_W_RESET  = 11'd1024;
    localparam logic [IMG_H_REG_W-1:0]  IMG_H_RESET  = 13'd1024;
    localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 5'd1;

    // Register map
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BLOCK_WIDTH  = 2'd2,
        CFG_BLOCK_HEIGHT = 2'd3
    } cfg_index_t;

    // Position flags that travel with a finished block
    typedef struct packed {
        logic row_end;
        logic image_end;
    } bavg_flags_t;

endpackage

// ===== rtl/bavg_ram.sv =====
module bavg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bavg_front.sv =====
module bavg_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16,
    localparam int FW = $clog2(MAX_FACTOR + 1),
    localparam int AW = 2 * FW,
    localparam int SW = 8 + 2 * $clog2(MAX_FACTOR)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  bavg_pkg::cfg_index_t               cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel input
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [bavg_pkg::PIXEL_W-1:0]       pixel,
    // finished block job toward the queue
    output logic                               job_push,
    input  logic                               job_full,
    output logic [SW-1:0]                      job_sum,
    output logic [bavg_pkg::PIXEL_W-1:0]       job_origin,
    output logic [AW-1:0]                      job_pad,
    output logic [AW-1:0]                      job_area,
    output bavg_pkg::bavg_flags_t              job_flags
);

    import bavg_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WCW = (IMG_W_REG_W > XW + 1) ? IMG_W_REG_W : XW + 1;
    localparam int FCW = (FACTOR_REG_W > FW) ? FACTOR_REG_W : FW;
    localparam int EW  = SW + PIXEL_W;

    // configuration registers
    logic [IMG_W_REG_W-1:0]  image_width_reg;
    logic [IMG_H_REG_W-1:0]  image_height_reg;
    logic [FACTOR_REG_W-1:0] block_width_reg;
    logic [FACTOR_REG_W-1:0] block_height_reg;

    // position counters
    logic [XW-1:0]    x_reg, x_next;
    logic [XW-1:0]    col_reg, col_next;
    logic [FW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [FW-1:0]    rib_reg, rib_next;

    // effective settings
    logic [WCW-1:0]   w_ext;
    logic [XW-1:0]    w_m1;
    logic [ROW_W-1:0] h_m1;
    logic [FCW-1:0]   bw_ext, bh_ext;
    logic [FW-1:0]    bw_eff, bh_eff, bw_m1, bh_m1;
    logic [AW-1:0]    area, have;

    // classification of the incoming item
    logic        accept;
    logic        row_end, last_img_row, last_col, last_row, emit, first;

    // stage 1 (memory read-modify-write)
    logic              s1_valid_reg, s1_valid_next;
    logic [XW-1:0]     s1_col_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic              s1_first_reg;
    logic              s1_emit_reg;
    bavg_flags_t       s1_flags_reg;
    logic [AW-1:0]     s1_pad_reg;
    logic [AW-1:0]     s1_area_reg;
    logic              s1_go;

    // write bypass for a read that collided with a write
    logic              byp_valid_reg, byp_valid_next;
    logic [XW-1:0]     byp_col_reg;
    logic [EW-1:0]     byp_data_reg;

    logic [EW-1:0]     ram_rdata, old_entry, new_entry;
    logic [SW-1:0]     new_sum;
    logic [PIXEL_W-1:0] new_org;

    // Clamp register values to their legal ranges
    always_comb
    begin
        w_ext = WCW'(image_width_reg);
        if (w_ext == '0)
        begin
            w_m1 = '0;
        end
        else if (w_ext > WCW'(MAX_WIDTH))
        begin
            w_m1 = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = XW'(w_ext - WCW'(1));
        end

        if (image_height_reg == '0)
        begin
            h_m1 = '0;
        end
        else if (image_height_reg > IMG_H_REG_W'(HEIGHT_LIMIT))
        begin
            h_m1 = ROW_W'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            h_m1 = ROW_W'(image_height_reg - IMG_H_REG_W'(1));
        end

        bw_ext = FCW'(block_width_reg);
        if (bw_ext == '0)
        begin
            bw_eff = FW'(1);
        end
        else if (bw_ext > FCW'(MAX_FACTOR))
        begin
            bw_eff = FW'(MAX_FACTOR);
        end
        else
        begin
            bw_eff = FW'(bw_ext);
        end

        bh_ext = FCW'(block_height_reg);
        if (bh_ext == '0)
        begin
            bh_eff = FW'(1);
        end
        else if (bh_ext > FCW'(MAX_FACTOR))
        begin
            bh_eff = FW'(MAX_FACTOR);
        end
        else
        begin
            bh_eff = FW'(bh_ext);
        end

        bw_m1 = bw_eff - FW'(1);
        bh_m1 = bh_eff - FW'(1);
    end

    // Classify the pixel at the current position
    assign accept       = pixel_valid && pixel_ready;
    assign row_end      = (x_reg == w_m1);
    assign last_img_row = (row_reg == h_m1);
    assign last_col     = (in_col_reg == bw_m1) || row_end;
    assign last_row     = (rib_reg == bh_m1) || last_img_row;
    assign emit         = last_col && last_row;
    assign first        = (in_col_reg == '0) && (rib_reg == '0);
    assign area         = AW'(bw_eff) * AW'(bh_eff);
    assign have         = (AW'(in_col_reg) + AW'(1)) * (AW'(rib_reg) + AW'(1));

    // Position counter advance
    always_comb
    begin
        x_next      = x_reg;
        col_next    = col_reg;
        in_col_next = in_col_reg;
        row_next    = row_reg;
        rib_next    = rib_reg;
        if (cfg_write)
        begin
            x_next      = '0;
            col_next    = '0;
            in_col_next = '0;
            row_next    = '0;
            rib_next    = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                x_next      = '0;
                col_next    = '0;
                in_col_next = '0;
                if (last_img_row)
                begin
                    row_next = '0;
                    rib_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                    rib_next = (rib_reg == bh_m1) ? '0 : rib_reg + FW'(1);
                end
            end
            else
            begin
                x_next = x_reg + XW'(1);
                if (in_col_reg == bw_m1)
                begin
                    in_col_next = '0;
                    col_next    = col_reg + XW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + FW'(1);
                end
            end
        end
    end

    // Configuration registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_W_RESET;
            image_height_reg <= IMG_H_RESET;
            block_width_reg  <= FACTOR_RESET;
            block_height_reg <= FACTOR_RESET;
            x_reg            <= '0;
            col_reg          <= '0;
            in_col_reg       <= '0;
            row_reg          <= '0;
            rib_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_W_REG_W-1:0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_H_REG_W-1:0];
                    CFG_BLOCK_WIDTH:  block_width_reg  <= cfg_data[FACTOR_REG_W-1:0];
                    CFG_BLOCK_HEIGHT: block_height_reg <= cfg_data[FACTOR_REG_W-1:0];
                    default:          image_width_reg  <= image_width_reg;
                endcase
            end
            x_reg      <= x_next;
            col_reg    <= col_next;
            in_col_reg <= in_col_next;
            row_reg    <= row_next;
            rib_reg    <= rib_next;
        end
    end

    // Stage 1 moves on unless its finished block finds the queue full
    assign s1_go       = s1_valid_reg && (!s1_emit_reg || !job_full);
    assign pixel_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        byp_valid_next = accept ? s1_go : byp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    // Stage 1 payload and bypass capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg             <= col_reg;
            s1_px_reg              <= pixel;
            s1_first_reg           <= first;
            s1_emit_reg            <= emit;
            s1_flags_reg.row_end   <= row_end;
            s1_flags_reg.image_end <= row_end && last_img_row;
            s1_pad_reg             <= area - have;
            s1_area_reg            <= area;
            byp_col_reg            <= s1_col_reg;
            byp_data_reg           <= new_entry;
        end
    end

    // Column store: running sum and top-left pixel per block column
    bavg_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (new_entry),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Accumulate; the first pixel of a block starts a new sum
    always_comb
    begin
        old_entry = (byp_valid_reg && (byp_col_reg == s1_col_reg)) ? byp_data_reg : ram_rdata;
        if (s1_first_reg)
        begin
            new_sum = SW'(s1_px_reg);
            new_org = s1_px_reg;
        end
        else
        begin
            new_sum = old_entry[EW-1:PIXEL_W] + SW'(s1_px_reg);
            new_org = old_entry[PIXEL_W-1:0];
        end
        new_entry = {new_sum, new_org};
    end

    assign job_push   = s1_go && s1_emit_reg;
    assign job_sum    = new_sum;
    assign job_origin = new_org;
    assign job_pad    = s1_pad_reg;
    assign job_area   = s1_area_reg;
    assign job_flags  = s1_flags_reg;

endmodule

// ===== rtl/bavg_queue.sv =====
module bavg_queue #(
    parameter int WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] dout
);

    import bavg_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/bavg_back.sv =====
module bavg_back #(
    parameter int MAX_FACTOR = 16,
    localparam int FW = $clog2(MAX_FACTOR + 1),
    localparam int AW = 2 * FW,
    localparam int SW = 8 + 2 * $clog2(MAX_FACTOR)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // job from the queue
    input  logic                          job_valid,
    output logic                          job_pop,
    input  logic [SW-1:0]                 job_sum,
    input  logic [bavg_pkg::PIXEL_W-1:0]  job_origin,
    input  logic [AW-1:0]                 job_pad,
    input  logic [AW-1:0]                 job_area,
    input  bavg_pkg::bavg_flags_t         job_flags,
    // result output
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [bavg_pkg::PIXEL_W-1:0]  average,
    output logic                          row_end,
    output logic                          image_end
);

    import bavg_pkg::*;

    localparam int QW = PIXEL_W;
    localparam int DW = AW + QW;

    logic [QW:0]          valid_reg, valid_next;
    logic [DW-1:0]        rem_reg  [QW];
    logic [QW-1:0]        quo_reg  [QW+1];
    logic [AW-1:0]        area_reg [QW];
    bavg_flags_t          flags_reg [QW+1];
    logic [AW+QW-1:0]     pad_prod;
    logic                 advance;

    // Whole pipeline moves when the output register is free or drained
    assign advance = !valid_reg[QW] || result_ready;
    assign job_pop = advance && job_valid;

    always_comb
    begin
        valid_next = advance ? {valid_reg[QW-1:0], job_valid} : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0: pad the cut-off block with its top-left pixel
    assign pad_prod = job_pad * job_origin;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]   <= DW'(job_sum) + DW'(pad_prod);
            quo_reg[0]   <= '0;
            area_reg[0]  <= job_area;
            flags_reg[0] <= job_flags;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar i = 1; i <= QW; i++)
    begin : g_div
        logic [DW-1:0] cmp;
        logic          ge;

        assign cmp = DW'(area_reg[i-1]) << (QW - i);
        assign ge  = (rem_reg[i-1] >= cmp);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                quo_reg[i]   <= {quo_reg[i-1][QW-2:0], ge};
                flags_reg[i] <= flags_reg[i-1];
            end
        end

        if (i < QW)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[i]  <= ge ? rem_reg[i-1] - cmp : rem_reg[i-1];
                    area_reg[i] <= area_reg[i-1];
                end
            end
        end
    end

    assign result_valid = valid_reg[QW];
    assign average      = quo_reg[QW];
    assign row_end      = flags_reg[QW].row_end;
    assign image_end    = flags_reg[QW].image_end;

endmodule

// ===== rtl/block_average_downscaler.sv =====
// Block average downscaler: box-filter decimation of a raster gray image.
// Throughput: one pixel per cycle; a stall only comes from a full job queue
// when results are not taken. A block's result passes through 1 memory
// read-modify-write stage, the job queue, 1 padding multiply stage and
// 8 divide stages, one quotient bit each.
// Reset clears counters, queue and pipeline valids and loads register
// defaults; the column store is not cleared, each block's first pixel writes it.
module block_average_downscaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  bavg_pkg::cfg_index_t               cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [bavg_pkg::PIXEL_W-1:0]       pixel,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [bavg_pkg::PIXEL_W-1:0]       average,
    output logic                               row_end,
    output logic                               image_end
);

    import bavg_pkg::*;

    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int AW = 2 * FW;
    localparam int SW = 8 + 2 * $clog2(MAX_FACTOR);
    localparam int JW = SW + PIXEL_W + 2 * AW + $bits(bavg_flags_t);

    logic              f_push, f_full;
    logic [SW-1:0]     f_sum;
    logic [PIXEL_W-1:0] f_origin;
    logic [AW-1:0]     f_pad, f_area;
    bavg_flags_t       f_flags;

    logic              q_not_empty, q_pop;
    logic [JW-1:0]     q_dout;
    logic [SW-1:0]     q_sum;
    logic [PIXEL_W-1:0] q_origin;
    logic [AW-1:0]     q_pad, q_area;
    bavg_flags_t       q_flags;

    // Front: position tracking and per-column accumulation
    bavg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .job_push    (f_push),
        .job_full    (f_full),
        .job_sum     (f_sum),
        .job_origin  (f_origin),
        .job_pad     (f_pad),
        .job_area    (f_area),
        .job_flags   (f_flags)
    );

    // Job queue between accumulation and division
    bavg_queue #(
        .WIDTH (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .din       ({f_sum, f_origin, f_pad, f_area, f_flags}),
        .full      (f_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    assign {q_sum, q_origin, q_pad, q_area, q_flags} = q_dout;

    // Back: padding and division into the average
    bavg_back #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_not_empty),
        .job_pop      (q_pop),
        .job_sum      (q_sum),
        .job_origin   (q_origin),
        .job_pad      (q_pad),
        .job_area     (q_area),
        .job_flags    (q_flags),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .row_end      (row_end),
        .image_end    (image_end)
    );

endmodule
